@@ rtl/core/udst_pkg.sv @@
package udst_pkg;

  // Fixed field widths of the request and the response.
  localparam int unsigned UUID_W  = 64;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_RANGE   = 2'd3
  } status_e;

  typedef struct packed {
    action_e            action;
    logic [UUID_W-1:0]  uuid_high;
    logic [UUID_W-1:0]  uuid_low;
    logic [IDX_W-1:0]   entry_index;
  } req_t;

  typedef struct packed {
    logic               found;
    status_e            status;
    logic [COUNT_W-1:0] entry_count;
    logic [UUID_W-1:0]  entry_high;
    logic [UUID_W-1:0]  entry_low;
  } rsp_t;

endpackage

@@ rtl/core/udst_if.sv @@
// Request channel into the table.
interface udst_req_if;
  import udst_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// Response channel out of the table.
interface udst_rsp_if;
  import udst_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/uuid_dedup_set_table.sv @@
// Channel   Direction  Interface    Payload fields
// req_i     in         udst_req_if  action, uuid_high, uuid_low, entry_index
// rsp_o     out        udst_rsp_if  found, status, entry_count, entry_high, entry_low
//
// One request is handled at a time. Insert and lookup scan the held entries
// through the single read port of the entry memory, one entry per cycle,
// and a match ends the scan early. Read and clear skip the scan and go
// straight to the finish state.
// The response sits in an output register, so a new request is taken while
// the previous response still waits for rsp_o.ready.
// Reset empties the set; the entry memory itself is not cleared.
module uuid_dedup_set_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  udst_req_if.sink          req_i,
  udst_rsp_if.source        rsp_o
);
  import udst_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IW = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned KW = 2 * UUID_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   ptr_q;
  logic            cmp_vld_q;
  logic [KW-1:0]   key_q;
  action_e         act_q;
  logic            res_found_q;
  status_e         res_status_q;
  logic            res_rd_q;
  logic            rsp_valid_q;
  rsp_t            rsp_q;

  // Entry memory: high half in the upper bits, low half in the lower bits.
  logic [KW-1:0]   mem_q [TABLE_DEPTH];
  logic [KW-1:0]   rdata_q;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic            rd_ok;
  logic            hit;
  logic            more;
  logic            scan_done;
  logic            full;
  logic            slot_free;

  // Handshake and scan decisions.
  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    rsp_o.valid = rsp_valid_q;
    rsp_o.payload = rsp_q;
    slot_free = !rsp_valid_q || rsp_o.ready;

    rd_ok = IW'(req_i.payload.entry_index) < IW'(count_q);
    hit = cmp_vld_q && (rdata_q == key_q);
    more = ptr_q < count_q;
    scan_done = hit || (!more && !cmp_vld_q);
    full = count_q >= CW'(TABLE_DEPTH);

    wr_en = (state_q == ST_SCAN) && scan_done && !hit && (act_q == ACT_INSERT) && !full;

    rd_en = 1'b0;
    rd_addr = ptr_q[AW-1:0];
    if (state_q == ST_IDLE) begin
      rd_en = req_i.valid && (req_i.payload.action == ACT_READ) && rd_ok;
      rd_addr = AW'(req_i.payload.entry_index);
    end else if (state_q == ST_SCAN) begin
      rd_en = !scan_done && more;
    end
  end

  // Entry memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= key_q;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Sequencer, count and response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      ptr_q        <= '0;
      cmp_vld_q    <= 1'b0;
      key_q        <= '0;
      act_q        <= ACT_INSERT;
      res_found_q  <= 1'b0;
      res_status_q <= STAT_OK;
      res_rd_q     <= 1'b0;
      rsp_valid_q  <= 1'b0;
      rsp_q        <= '0;
    end else begin
      // A taken response frees the output register unless a new one replaces it.
      if (rsp_o.ready && !((state_q == ST_FINISH) && slot_free)) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            key_q        <= {req_i.payload.uuid_high, req_i.payload.uuid_low};
            act_q        <= req_i.payload.action;
            res_found_q  <= 1'b0;
            ptr_q        <= '0;
            cmp_vld_q    <= 1'b0;
            case (req_i.payload.action) inside
              ACT_INSERT, ACT_LOOKUP: begin
                res_status_q <= STAT_OK;
                res_rd_q     <= 1'b0;
                state_q      <= ST_SCAN;
              end
              ACT_READ: begin
                res_rd_q     <= rd_ok;
                res_status_q <= rd_ok ? STAT_OK : STAT_RANGE;
                state_q      <= ST_FINISH;
              end
              default: begin
                res_status_q <= STAT_OK;
                res_rd_q     <= 1'b0;
                count_q      <= '0;
                state_q      <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            res_found_q <= hit;
            if (act_q == ACT_INSERT) begin
              if (hit) begin
                res_status_q <= STAT_PRESENT;
              end else if (full) begin
                res_status_q <= STAT_FULL;
              end else begin
                count_q <= CW'(count_q + 1'b1);
              end
            end
            state_q <= ST_FINISH;
          end else begin
            // Issue the next read while comparing the previous entry.
            if (more) begin
              ptr_q <= CW'(ptr_q + 1'b1);
            end
            cmp_vld_q <= more;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            rsp_valid_q         <= 1'b1;
            rsp_q.found         <= res_found_q;
            rsp_q.status        <= res_status_q;
            rsp_q.entry_count   <= COUNT_W'(count_q);
            rsp_q.entry_high    <= res_rd_q ? rdata_q[KW-1:UUID_W] : '0;
            rsp_q.entry_low     <= res_rd_q ? rdata_q[UUID_W-1:0] : '0;
            state_q             <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/udst_checker.sv @@
module udst_checker #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input udst_pkg::rsp_t rsp_i
);
  import udst_pkg::*;

  // A held response keeps its contents until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_i))
    else $error("response changed while stalled");

  // One request at a time: the table is busy right after taking one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // A refused insert reports a full table and no match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_i.status == STAT_FULL) |->
      (rsp_i.entry_count == COUNT_W'(TABLE_DEPTH)) && !rsp_i.found)
    else $error("full status with wrong count or found");

  // Out-of-range reads return zero entry fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_i.status == STAT_RANGE) |->
      (rsp_i.entry_high == '0) && (rsp_i.entry_low == '0) && !rsp_i.found)
    else $error("range error with entry data");

  // A match is only reported as present or as a plain lookup hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.found |->
      (rsp_i.status == STAT_OK) || (rsp_i.status == STAT_PRESENT))
    else $error("found with inconsistent status");

endmodule

bind uuid_dedup_set_table udst_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_udst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_i       (rsp_o.payload)
);
